### sv/hhrc_pkg.sv
// shared constants and types for the hsv/hsl to rgb converter
`timescale 1ns / 1ps

package hhrc_pkg;

	localparam int HUE_W = 15;
	localparam int CH_W = 8;
	localparam int HUE_FRAC_BITS_DEF = 6;

	localparam int APB_AW = 3;
	localparam int APB_DW = 32;

	// register index, taken from paddr[APB_AW-1:2]
	localparam logic REG_COLOR_MODEL = 1'b0;

	localparam logic MODEL_HSV = 1'b0;
	localparam logic MODEL_HSL = 1'b1;

	typedef enum logic [2:0] {
		SECT_0 = 3'd0,
		SECT_1 = 3'd1,
		SECT_2 = 3'd2,
		SECT_3 = 3'd3,
		SECT_4 = 3'd4,
		SECT_5 = 3'd5
	} sector_t;

endpackage

### sv/hhrc_pixel_if.sv
// pixel input channel: hue, saturation, value or lightness and alpha
`timescale 1ns / 1ps

interface hhrc_pixel_if import hhrc_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [HUE_W-1:0]  hue;
	logic [CH_W-1:0]   saturation;
	logic [CH_W-1:0]   value_or_lightness;
	logic [CH_W-1:0]   alpha_in;

	modport source (
		output valid, hue, saturation, value_or_lightness, alpha_in,
		input  ready
	);

	modport sink (
		input  valid, hue, saturation, value_or_lightness, alpha_in,
		output ready
	);
endinterface

### sv/hhrc_rgba_if.sv
// rgba result channel
`timescale 1ns / 1ps

interface hhrc_rgba_if import hhrc_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [CH_W-1:0]  red;
	logic [CH_W-1:0]  green;
	logic [CH_W-1:0]  blue;
	logic [CH_W-1:0]  alpha_out;

	modport source (
		output valid, red, green, blue, alpha_out,
		input  ready
	);

	modport sink (
		input  valid, red, green, blue, alpha_out,
		output ready
	);
endinterface

### sv/hsv_hsl_to_rgb_convert_unit.sv
// top level: pipelined hsv/hsl to rgba pixel converter with apb register port
//
// channel   direction  handshake        payload
// pixel     in         valid / ready    hue, saturation, value_or_lightness, alpha_in
// rgba      out        valid / ready    red, green, blue, alpha_out
// apb       in         psel / penable   color_model at byte address 0
//
// one word per clock while the output is not stalled; five register stages from acceptance to the output register
// stage 1 hue sector and product, stage 2 chroma terms, stage 3 and 4 reciprocal
// multiplies, stage 5 channel placement; no stage chains two multipliers
// reset clears the valid bits and color_model; payload registers are not reset
// a stalled output holds each stage that is full, empty stages still fill
`timescale 1ns / 1ps

module hsv_hsl_to_rgb_convert_unit import hhrc_pkg::*; #(
	parameter int HUE_FRAC_BITS = HUE_FRAC_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	hhrc_pixel_if.sink          pixel,
	hhrc_rgba_if.source         rgba,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [APB_AW-1:0]   paddr,
	input  logic [APB_DW-1:0]   pwdata,
	output logic [APB_DW-1:0]   prdata,
	output logic                pready
);

	localparam int D = 60 << HUE_FRAC_BITS;
	localparam int D6 = 6 * D;
	localparam int DW = $clog2(D + 1);
	localparam int TW = DW + 1;
	localparam int XW = 17 + DW;
	localparam int YW = XW - HUE_FRAC_BITS - 2;
	localparam int S15 = YW + 4;
	localparam int M15 = (2 ** S15) / 15 + 1;
	localparam int M15W = $clog2(M15 + 1);
	localparam int PW15 = YW + M15W;
	localparam int S255 = 25;
	localparam int M255 = (2 ** S255) / 255 + 1;

	localparam logic [DW-1:0] D_C = DW'(D);
	localparam logic [TW-1:0] D_T = TW'(D);

	function automatic logic [8:0] div255(input logic [16:0] z);
		logic [34:0] prod;
		prod = 35'(z) * 35'(M255);
		return 9'(prod >> S255);
	endfunction

	// configuration register
	logic color_model_q;

	assign pready = 1'b1;
	assign prdata = (paddr[APB_AW-1:2] == REG_COLOR_MODEL) ?
		APB_DW'(color_model_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			color_model_q <= MODEL_HSV;
		end else if (psel && penable && pwrite && pready &&
				paddr[APB_AW-1:2] == REG_COLOR_MODEL) begin
			color_model_q <= pwdata[0];
		end
	end

	// stage enables
	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic en1, en2, en3, en4, en5;

	assign en5 = !v_s5 || rgba.ready;
	assign en4 = !v_s4 || en5;
	assign en3 = !v_s3 || en4;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;
	assign pixel.ready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (en1) v_s1 <= pixel.valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
			if (en5) v_s5 <= v_s4;
		end
	end

	// stage 1: hue sector, position within sector pair, chroma product
	logic [31:0]    hue_ext;
	logic [31:0]    base_w;
	sector_t        sect_w;
	logic [TW-1:0]  t_w;
	logic [DW-1:0]  dist_w;
	logic [DW-1:0]  f_w;
	logic [8:0]     twol_w;
	logic [8:0]     absd_w;
	logic [7:0]     q_w;
	logic [15:0]    p_w;

	always_comb begin
		hue_ext = 32'(pixel.hue);
		if (hue_ext >= 32'(D6)) begin
			hue_ext = '0;
		end
		sect_w = SECT_0;
		for (int k = 1; k < 6; k++) begin
			if (hue_ext >= 32'(k * D)) begin
				sect_w = sector_t'(3'(k));
			end
		end
		case (sect_w) inside
			SECT_0, SECT_1: base_w = '0;
			SECT_2, SECT_3: base_w = 32'(2 * D);
			default:        base_w = 32'(4 * D);
		endcase
		t_w = TW'(hue_ext - base_w);
		dist_w = (t_w >= D_T) ? DW'(t_w - D_T) : DW'(D_T - t_w);
		f_w = D_C - dist_w;

		twol_w = {pixel.value_or_lightness, 1'b0};
		absd_w = (twol_w >= 9'd255) ? twol_w - 9'd255 : 9'd255 - twol_w;
		q_w = 8'(9'd255 - absd_w);
		if (color_model_q == MODEL_HSL) begin
			p_w = 16'(q_w) * 16'(pixel.saturation);
		end else begin
			p_w = 16'(pixel.value_or_lightness) * 16'(pixel.saturation);
		end
	end

	logic [15:0]    p_s1;
	logic [7:0]     vl_s1;
	logic           model_s1;
	sector_t        sect_s1;
	logic [DW-1:0]  f_s1;
	logic [7:0]     alpha_s1;

	always_ff @(posedge clk) begin
		if (en1 && pixel.valid) begin
			p_s1 <= p_w;
			vl_s1 <= pixel.value_or_lightness;
			model_s1 <= color_model_q;
			sect_s1 <= sect_w;
			f_s1 <= f_w;
			alpha_s1 <= pixel.alpha_in;
		end
	end

	// stage 2: low and high numerators, secondary product
	logic [16:0] vl510_w;
	logic [16:0] l0_w;
	logic [16:0] h0_w;

	always_comb begin
		vl510_w = 17'(vl_s1) * 17'd510;
		if (model_s1 == MODEL_HSL) begin
			l0_w = vl510_w - 17'(p_s1);
			h0_w = vl510_w + 17'(p_s1);
		end else begin
			l0_w = vl510_w - {p_s1, 1'b0};
			h0_w = vl510_w;
		end
	end

	logic [16:0]    l0_s2;
	logic [16:0]    h0_s2;
	logic [XW-1:0]  x_s2;
	sector_t        sect_s2;
	logic [7:0]     alpha_s2;

	always_ff @(posedge clk) begin
		if (en2 && v_s1) begin
			l0_s2 <= l0_w;
			h0_s2 <= h0_w;
			x_s2 <= XW'({p_s1, 1'b0}) * XW'(f_s1);
			sect_s2 <= sect_s1;
			alpha_s2 <= alpha_s1;
		end
	end

	// stage 3: secondary term over the sector width, low and high channels
	logic [YW-1:0]   y_w;
	logic [PW15-1:0] prod15_w;

	assign y_w = x_s2[XW-1:HUE_FRAC_BITS+2];
	assign prod15_w = PW15'(y_w) * PW15'(M15);

	logic [16:0]  l0_s3;
	logic [16:0]  k_s3;
	logic [8:0]   lo_ch_s3;
	logic [8:0]   hi_ch_s3;
	sector_t      sect_s3;
	logic [7:0]   alpha_s3;

	always_ff @(posedge clk) begin
		if (en3 && v_s2) begin
			l0_s3 <= l0_s2;
			k_s3 <= 17'(prod15_w >> S15);
			lo_ch_s3 <= div255({1'b0, l0_s2[16:1]});
			hi_ch_s3 <= div255({1'b0, h0_s2[16:1]});
			sect_s3 <= sect_s2;
			alpha_s3 <= alpha_s2;
		end
	end

	// stage 4: middle channel
	logic [17:0] w_w;

	assign w_w = 18'(l0_s3) + 18'(k_s3);

	logic [8:0]   lo_ch_s4;
	logic [8:0]   hi_ch_s4;
	logic [8:0]   mid_ch_s4;
	sector_t      sect_s4;
	logic [7:0]   alpha_s4;

	always_ff @(posedge clk) begin
		if (en4 && v_s3) begin
			lo_ch_s4 <= lo_ch_s3;
			hi_ch_s4 <= hi_ch_s3;
			mid_ch_s4 <= div255(w_w[17:1]);
			sect_s4 <= sect_s3;
			alpha_s4 <= alpha_s3;
		end
	end

	// stage 5: place channels by sector, output register
	logic [7:0] lo_w, hi_w, mid_w;
	logic [7:0] red_w, green_w, blue_w;

	always_comb begin
		lo_w = (lo_ch_s4 > 9'd255) ? 8'd255 : lo_ch_s4[7:0];
		hi_w = (hi_ch_s4 > 9'd255) ? 8'd255 : hi_ch_s4[7:0];
		mid_w = (mid_ch_s4 > 9'd255) ? 8'd255 : mid_ch_s4[7:0];
		case (sect_s4)
			SECT_0: begin
				red_w = hi_w; green_w = mid_w; blue_w = lo_w;
			end
			SECT_1: begin
				red_w = mid_w; green_w = hi_w; blue_w = lo_w;
			end
			SECT_2: begin
				red_w = lo_w; green_w = hi_w; blue_w = mid_w;
			end
			SECT_3: begin
				red_w = lo_w; green_w = mid_w; blue_w = hi_w;
			end
			SECT_4: begin
				red_w = mid_w; green_w = lo_w; blue_w = hi_w;
			end
			default: begin
				red_w = hi_w; green_w = lo_w; blue_w = mid_w;
			end
		endcase
	end

	logic [7:0] red_s5, green_s5, blue_s5, alpha_s5;

	always_ff @(posedge clk) begin
		if (en5 && v_s4) begin
			red_s5 <= red_w;
			green_s5 <= green_w;
			blue_s5 <= blue_w;
			alpha_s5 <= alpha_s4;
		end
	end

	assign rgba.valid = v_s5;
	assign rgba.red = red_s5;
	assign rgba.green = green_s5;
	assign rgba.blue = blue_s5;
	assign rgba.alpha_out = alpha_s5;

	// checks
	a_hi_not_below_lo: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 |-> h0_s2 >= l0_s2)
		else $error("high numerator below low numerator");

	a_channel_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 |-> (hi_ch_s3 <= 9'd255) && (lo_ch_s3 <= hi_ch_s3))
		else $error("low or high channel out of range");

	a_stall_holds_mid: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s4 && !en5) |=> v_s4 && $stable(mid_ch_s4))
		else $error("stalled stage 4 lost its word");

	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && !en2) |-> !pixel.ready)
		else $error("input accepted into a blocked stage 1");

endmodule

### verif/hsv_hsl_to_rgb_convert_unit_tb.sv
// testbench for the hsv/hsl to rgba converter: directed and random pixels checked word by word
`timescale 1ns / 1ps

module hsv_hsl_to_rgb_convert_unit_tb;
	import hhrc_pkg::*;

	localparam longint unsigned SECT_SPAN = 64'd60 << HUE_FRAC_BITS_DEF;
	localparam longint unsigned FULL_CIRCLE = 6 * SECT_SPAN;
	localparam longint unsigned CHAN_DEN = 510 * SECT_SPAN;
	localparam logic REG_UNMAPPED = 1'b1;
	localparam int LONG_HOLD_CYCLES = 300;
	localparam int RAND_PIXELS_PER_PHASE = 210;

	typedef struct packed {
		logic [HUE_W-1:0] hue;
		logic [CH_W-1:0]  sat;
		logic [CH_W-1:0]  vl;
		logic [CH_W-1:0]  alpha;
	} pixel_t;

	typedef struct packed {
		logic [CH_W-1:0] red;
		logic [CH_W-1:0] green;
		logic [CH_W-1:0] blue;
		logic [CH_W-1:0] alpha_out;
	} rgba_t;

	logic clk = 1'b0;
	logic arst_n;
	logic psel, penable, pwrite;
	logic [APB_AW-1:0] paddr;
	logic [APB_DW-1:0] pwdata;
	logic [APB_DW-1:0] prdata;
	logic pready;

	hhrc_pixel_if pixel_ch ();
	hhrc_rgba_if rgba_ch ();

	hsv_hsl_to_rgb_convert_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.pixel(pixel_ch),
		.rgba(rgba_ch),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always #2 clk = ~clk;

	pixel_t pixel_queue[$];
	rgba_t rgba_expect[$];
	pixel_t taken_px;
	logic color_model_sel = MODEL_HSV;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int long_hold_reqs = 0;
	int long_hold_seen = 0;
	int long_hold_left = 0;
	int error_cnt = 0;

	function automatic logic [CH_W-1:0] chan_level(input longint unsigned num);
		longint unsigned q;
		q = num / CHAN_DEN;
		return (q > 255) ? 8'd255 : q[CH_W-1:0];
	endfunction

	function automatic rgba_t convert_pixel(input logic model, input pixel_t px);
		longint unsigned h, s, v, q, p, lo, hi, mid, t, f;
		rgba_t res;
		h = px.hue;
		s = px.sat;
		v = px.vl;
		if (h >= FULL_CIRCLE)
			h = 0;
		if (model == MODEL_HSL) begin
			q = 255 - ((2 * v >= 255) ? 2 * v - 255 : 255 - 2 * v);
			p = q * s;
			lo = 510 * v * SECT_SPAN - p * SECT_SPAN;
		end else begin
			p = s * v;
			lo = 510 * v * SECT_SPAN - 2 * p * SECT_SPAN;
		end
		t = h % (2 * SECT_SPAN);
		f = SECT_SPAN - ((t >= SECT_SPAN) ? t - SECT_SPAN : SECT_SPAN - t);
		hi = lo + 2 * p * SECT_SPAN;
		mid = lo + 2 * p * f;
		case (sector_t'(h / SECT_SPAN))
			SECT_0: begin
				res.red = chan_level(hi);  res.green = chan_level(mid); res.blue = chan_level(lo);
			end
			SECT_1: begin
				res.red = chan_level(mid); res.green = chan_level(hi);  res.blue = chan_level(lo);
			end
			SECT_2: begin
				res.red = chan_level(lo);  res.green = chan_level(hi);  res.blue = chan_level(mid);
			end
			SECT_3: begin
				res.red = chan_level(lo);  res.green = chan_level(mid); res.blue = chan_level(hi);
			end
			SECT_4: begin
				res.red = chan_level(mid); res.green = chan_level(lo);  res.blue = chan_level(hi);
			end
			default: begin
				res.red = chan_level(hi);  res.green = chan_level(lo);  res.blue = chan_level(mid);
			end
		endcase
		res.alpha_out = px.alpha;
		return res;
	endfunction

	function automatic logic [CH_W-1:0] pick_level();
		case ($urandom_range(7))
			0: return 8'd0;
			1: return 8'd255;
			default: return CH_W'($urandom_range(255));
		endcase
	endfunction

	task automatic queue_pixel(input int hue, input int sat, input int vl, input int alpha);
		pixel_t px;
		px.hue = HUE_W'(hue);
		px.sat = CH_W'(sat);
		px.vl = CH_W'(vl);
		px.alpha = CH_W'(alpha);
		pixel_queue.push_back(px);
	endtask

	task automatic wait_drained();
		while (pixel_queue.size() != 0 || rgba_expect.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic reg_write(input logic idx, input logic [APB_DW-1:0] data);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (idx == REG_COLOR_MODEL)
			color_model_sel = data[0];
	endtask

	task automatic queue_directed();
		queue_pixel(0, 255, 255, 255);
		queue_pixel(23039, 255, 255, 0);
		queue_pixel(23040, 200, 128, 17);
		queue_pixel(32767, 255, 255, 255);
		queue_pixel(3840, 255, 255, 128);
		queue_pixel(11520, 128, 200, 1);
		queue_pixel(19200, 255, 128, 255);
		queue_pixel(5000, 0, 173, 99);
		queue_pixel(15000, 0, 255, 0);
		queue_pixel(9000, 255, 0, 255);
		queue_pixel(16384, 170, 85, 42);
		queue_pixel(1920, 77, 200, 200);
	endtask

	task automatic queue_random(input int count);
		pixel_t px;
		for (int k = 0; k < count; k++) begin
			case ($urandom_range(9))
				0: px.hue = HUE_W'(SECT_SPAN * $urandom_range(6));
				1: px.hue = HUE_W'($urandom_range(32767, int'(FULL_CIRCLE)));
				2: px.hue = HUE_W'(SECT_SPAN * $urandom_range(5) + $urandom_range(1) * (SECT_SPAN - 1));
				default: px.hue = HUE_W'($urandom_range(int'(FULL_CIRCLE) - 1));
			endcase
			px.sat = pick_level();
			px.vl = pick_level();
			px.alpha = CH_W'($urandom_range(255));
			pixel_queue.push_back(px);
		end
	endtask

	// pixel driver: prediction is taken at the accepting edge
	always @(posedge clk) begin
		if (!arst_n) begin
			pixel_ch.valid <= 1'b0;
		end else begin
			if (pixel_ch.valid && pixel_ch.ready) begin
				taken_px.hue = pixel_ch.hue;
				taken_px.sat = pixel_ch.saturation;
				taken_px.vl = pixel_ch.value_or_lightness;
				taken_px.alpha = pixel_ch.alpha_in;
				rgba_expect.push_back(convert_pixel(color_model_sel, taken_px));
				void'(pixel_queue.pop_front());
			end
			if (!(pixel_ch.valid && !pixel_ch.ready)) begin
				if (pixel_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					pixel_ch.valid <= 1'b1;
					pixel_ch.hue <= pixel_queue[0].hue;
					pixel_ch.saturation <= pixel_queue[0].sat;
					pixel_ch.value_or_lightness <= pixel_queue[0].vl;
					pixel_ch.alpha_in <= pixel_queue[0].alpha;
				end else begin
					pixel_ch.valid <= 1'b0;
				end
			end
		end
	end

	// result receiver with random stalls and an occasional long hold-off
	always @(posedge clk) begin
		if (!arst_n) begin
			rgba_ch.ready <= 1'b0;
		end else begin
			if (long_hold_seen != long_hold_reqs) begin
				long_hold_seen = long_hold_reqs;
				long_hold_left = LONG_HOLD_CYCLES;
			end
			if (long_hold_left != 0) begin
				long_hold_left = long_hold_left - 1;
				rgba_ch.ready <= 1'b0;
			end else begin
				rgba_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	// result monitor
	always @(posedge clk) begin
		if (arst_n && rgba_ch.valid && rgba_ch.ready) begin
			if (rgba_expect.size() == 0) begin
				$error("unexpected rgba word: red %0d green %0d blue %0d alpha_out %0d",
					rgba_ch.red, rgba_ch.green, rgba_ch.blue, rgba_ch.alpha_out);
				error_cnt++;
			end else begin
				if (rgba_ch.red !== rgba_expect[0].red) begin
					$error("red expected %0d got %0d", rgba_expect[0].red, rgba_ch.red);
					error_cnt++;
				end
				if (rgba_ch.green !== rgba_expect[0].green) begin
					$error("green expected %0d got %0d", rgba_expect[0].green, rgba_ch.green);
					error_cnt++;
				end
				if (rgba_ch.blue !== rgba_expect[0].blue) begin
					$error("blue expected %0d got %0d", rgba_expect[0].blue, rgba_ch.blue);
					error_cnt++;
				end
				if (rgba_ch.alpha_out !== rgba_expect[0].alpha_out) begin
					$error("alpha_out expected %0d got %0d",
						rgba_expect[0].alpha_out, rgba_ch.alpha_out);
					error_cnt++;
				end
				void'(rgba_expect.pop_front());
			end
		end
	end

	initial begin
		#2_000_000;
		$display("[hsv_hsl_to_rgb_convert_unit] ERROR");
		$finish;
	end

	initial begin
		int send_pcts[4];
		int recv_pcts[4];
		send_pcts = '{0, 63, 0, 33};
		recv_pcts = '{0, 0, 63, 33};
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		pixel_ch.valid = 1'b0;
		pixel_ch.hue = '0;
		pixel_ch.saturation = '0;
		pixel_ch.value_or_lightness = '0;
		pixel_ch.alpha_in = '0;
		rgba_ch.ready = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		reg_write(REG_COLOR_MODEL, APB_DW'(MODEL_HSV));
		queue_directed();
		wait_drained();
		// only the low bit counts, and an unmapped index leaves the model alone
		reg_write(REG_COLOR_MODEL, 32'hFFFF_FFFF);
		reg_write(REG_UNMAPPED, 32'h0000_0000);
		queue_directed();
		wait_drained();

		for (int ph = 0; ph < 8; ph++) begin
			reg_write(REG_COLOR_MODEL, ($urandom() & ~32'd1) | APB_DW'(ph % 2));
			if (ph == 5)
				reg_write(REG_UNMAPPED, APB_DW'($urandom()));
			send_idle_pct = send_pcts[ph / 2];
			recv_stall_pct = recv_pcts[ph / 2];
			if (ph == 1) begin
				queue_random(RAND_PIXELS_PER_PHASE);
				long_hold_reqs++;
			end else if (ph == 6) begin
				queue_random(RAND_PIXELS_PER_PHASE / 2);
				wait_drained();
				queue_random(RAND_PIXELS_PER_PHASE / 2);
			end else begin
				queue_random(RAND_PIXELS_PER_PHASE);
			end
			wait_drained();
		end

		repeat (20) @(posedge clk);
		if (rgba_expect.size() != 0) begin
			$error("%0d rgba words never arrived", rgba_expect.size());
			error_cnt++;
		end
		if (error_cnt == 0)
			$display("[hsv_hsl_to_rgb_convert_unit] OK");
		else
			$display("[hsv_hsl_to_rgb_convert_unit] ERROR");
		$finish;
	end

endmodule
